/* rtl/iac_pkg.sv */
`default_nettype none
package iac_pkg;
    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int EPS = (ONE + 500) / 1000;
    localparam int THRESH_RESET = (ONE * 2 + 5) / 10;
    localparam int CFG_W = 23;
    localparam int VAL_W = 18;
    localparam int SCALE_W = 24;
    localparam int ACC_W = 32;
    localparam int PROD_W = 2 * SCALE_W;
    localparam int FLAG_W = 6;
    localparam int FL_PRESS = 0;
    localparam int FL_TRIG = 1;
    localparam int FL_REL = 2;
    localparam int FL_HASTOG = 3;
    localparam int FL_ON = 4;
    localparam int FL_OFF = 5;

    typedef enum logic [0:0] {
        REG_WINDOW = 1'b0,
        REG_THRESH = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_BUTTON  = 3'd1,
        K_TOGGLE  = 3'd2,
        K_ANALOG  = 3'd3,
        K_DIGITAL = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [SCALE_W-1:0] scale;
        logic [CFG_W-1:0]          deadzone;
        logic                      pressed;
        logic                      press_edge;
        logic                      release_edge;
        logic signed [SCALE_W-1:0] axis_sample;
        logic [CFG_W-1:0]          frame_time;
        logic                      last;
    } t_item;

    typedef struct packed {
        logic             start;
        logic [CFG_W-1:0] num;
        logic [CFG_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

/* rtl/iac_front.sv */
`default_nettype none
module iac_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_is_axis,
    input  wire logic                       i_digital_mode,
    input  wire logic                       i_toggle_mode,
    input  wire logic signed [23:0]         i_scale,
    input  wire logic [22:0]                i_deadzone,
    input  wire logic                       i_pressed,
    input  wire logic                       i_press_edge,
    input  wire logic                       i_release_edge,
    input  wire logic signed [23:0]         i_axis_sample,
    input  wire logic [22:0]                i_frame_time,
    input  wire logic                       i_binding_valid,
    input  wire logic                       i_last,
    output iac_pkg::t_item                  o_head,
    output logic                            o_head_valid,
    input  wire logic                       i_pop
);
    import iac_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    t_item      word;
    logic       push;
    logic       pop;

    // classify the binding
    always_comb begin
        word.scale        = i_scale;
        word.deadzone     = i_deadzone;
        word.pressed      = i_pressed;
        word.press_edge   = i_press_edge;
        word.release_edge = i_release_edge;
        word.axis_sample  = i_axis_sample;
        word.frame_time   = i_frame_time;
        word.last         = i_last;
        if (!i_binding_valid) begin
            word.kind = K_NONE;
        end else if (!i_is_axis) begin
            word.kind = i_toggle_mode ? K_TOGGLE : K_BUTTON;
        end else begin
            word.kind = i_digital_mode ? K_DIGITAL : K_ANALOG;
        end
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/iac_div.sv */
`default_nettype none
module iac_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire iac_pkg::t_div_req   i_req,
    output iac_pkg::t_div_rsp        o_rsp
);
    import iac_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [CFG_W:0]       r_rem;
    logic [CFG_W-1:0]     r_den;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CFG_W:0]       rem2;
    logic                 fits;

    // restoring division, one quotient bit a cycle
    assign rem2 = {r_rem[CFG_W-1:0], 1'b0};
    assign fits = (rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? (rem2 - {1'b0, r_den}) : rem2;
            r_quo <= {r_quo[FRAC_BITS-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

/* rtl/iac_back.sv */
`default_nettype none
module iac_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire iac_pkg::t_item              i_head,
    input  wire logic                        i_head_valid,
    output logic                             o_pop,
    input  wire logic [22:0]                 i_window,
    input  wire logic [22:0]                 i_thresh,
    output iac_pkg::t_div_req                o_div_req,
    input  wire iac_pkg::t_div_rsp           i_div_rsp,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic signed [17:0]               o_action_value,
    output logic                             o_action_active,
    output logic                             o_action_triggered,
    output logic                             o_action_released
);
    import iac_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_END  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    localparam int SP_W = VAL_W + 1 + FRAC_BITS + 1;
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(ONE);
    localparam logic signed [ACC_W-1:0] ACC_MONE = -ACC_ONE;
    localparam logic signed [PROD_W-1:0] P_MAX = (PROD_W'(1) <<< (ACC_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] P_MIN = -P_MAX - PROD_W'(1);

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return $signed(s[ACC_W-1:0]);
    endfunction

    t_state                     r_state;
    t_item                      r_item;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_sum;
    logic [FLAG_W-1:0]          r_flags;
    logic                       r_latch;
    logic signed [SCALE_W-1:0]  r_gain;
    logic signed [VAL_W-1:0]    r_last;
    logic signed [VAL_W-1:0]    r_v;
    logic                       r_smooth;
    logic [FRAC_BITS-1:0]       r_t;
    logic signed [SP_W-1:0]     r_sprod;
    logic                       r_out_valid;
    logic signed [VAL_W-1:0]    r_out_value;
    logic                       r_out_act;
    logic                       r_out_trig;
    logic                       r_out_rel;

    logic signed [ACC_W-1:0]    n_sum;
    logic [FLAG_W-1:0]          n_flags;
    logic                       n_latch;
    logic signed [SCALE_W-1:0]  n_gain;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [ACC_W-1:0]    a_val;
    logic [ACC_W-1:0]           mag_a;
    logic [ACC_W-1:0]           dz_ext;
    logic [VAL_W-1:0]           mag_last;
    logic signed [ACC_W-1:0]    scale_ext;
    logic                       act_ax;

    logic signed [ACC_W-1:0]    v_tmp;
    logic [FLAG_W-1:0]          end_flags;
    logic signed [VAL_W:0]      diff;
    logic signed [SP_W-1:0]     sp_sh;
    logic signed [VAL_W-1:0]    s_val;
    logic [VAL_W-1:0]           mag_s;
    logic                       f_act;
    logic                       f_trig;
    logic                       f_rel;
    logic                       out_free;
    logic                       out_load;

    // per binding accumulate
    always_comb begin
        prod_sh   = r_prod >>> FRAC_BITS;
        if (prod_sh > P_MAX) begin
            a_val = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (prod_sh < P_MIN) begin
            a_val = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            a_val = prod_sh[ACC_W-1:0];
        end
        mag_a     = a_val[ACC_W-1] ? -a_val : a_val;
        dz_ext    = ACC_W'(r_item.deadzone);
        mag_last  = r_last[VAL_W-1] ? -r_last : r_last;
        scale_ext = ACC_W'(r_item.scale);
        act_ax    = (mag_a > dz_ext);
        n_sum     = r_sum;
        n_flags   = r_flags;
        n_latch   = r_latch;
        n_gain    = r_gain;
        unique case (r_item.kind)
            K_BUTTON, K_TOGGLE: begin
                if (r_item.pressed) n_flags[FL_PRESS] = 1'b1;
                if (r_item.press_edge) n_flags[FL_TRIG] = 1'b1;
                if (r_item.release_edge) n_flags[FL_REL] = 1'b1;
                if (r_item.kind == K_TOGGLE) begin
                    n_flags[FL_HASTOG] = 1'b1;
                    n_gain = r_item.scale;
                    if (r_item.press_edge) begin
                        n_latch = !r_latch;
                        if (!r_latch) begin
                            n_flags[FL_ON] = 1'b1;
                        end else begin
                            n_flags[FL_OFF] = 1'b1;
                        end
                    end
                end else if (r_item.pressed) begin
                    n_sum = sat_add(r_sum, scale_ext);
                end
            end
            K_ANALOG: begin
                if (act_ax) begin
                    n_sum = sat_add(r_sum, a_val);
                    n_flags[FL_PRESS] = 1'b1;
                end
            end
            K_DIGITAL: begin
                if (act_ax) begin
                    n_flags[FL_PRESS] = 1'b1;
                    n_sum = sat_add(r_sum, a_val[ACC_W-1] ? -scale_ext : scale_ext);
                    if (ACC_W'(mag_last) <= dz_ext) n_flags[FL_TRIG] = 1'b1;
                end else if (ACC_W'(mag_last) > dz_ext) begin
                    n_flags[FL_REL] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // end of frame value and flags
    always_comb begin
        v_tmp     = r_sum;
        end_flags = r_flags;
        if (r_flags[FL_HASTOG]) begin
            if (r_latch) begin
                v_tmp = sat_add(r_sum, ACC_W'(r_gain));
                end_flags[FL_PRESS] = 1'b1;
            end
            if (r_flags[FL_ON]) end_flags[FL_TRIG] = 1'b1;
            if (r_flags[FL_OFF]) end_flags[FL_REL] = 1'b1;
        end
        if (v_tmp > ACC_ONE) v_tmp = ACC_ONE;
        if (v_tmp < ACC_MONE) v_tmp = ACC_MONE;
    end

    // smoothing and edge detection
    always_comb begin
        diff  = {r_v[VAL_W-1], r_v} - {r_last[VAL_W-1], r_last};
        sp_sh = r_sprod >>> FRAC_BITS;
        s_val = r_smooth ? (r_last + sp_sh[VAL_W-1:0]) : r_v;
        mag_s = s_val[VAL_W-1] ? -s_val : s_val;
        f_act = r_flags[FL_PRESS] || (mag_s > VAL_W'(EPS));
        f_trig = r_flags[FL_TRIG] || ((i_thresh != '0) &&
                 (CFG_W'(mag_s) >= i_thresh) && (CFG_W'(mag_last) < i_thresh));
        f_rel = r_flags[FL_REL] || ((i_thresh != '0) &&
                ((CFG_W+1)'({mag_s, 1'b0}) <= {1'b0, i_thresh}) &&
                ((CFG_W+1)'({mag_last, 1'b0}) > {1'b0, i_thresh}));
    end

    assign out_free = !r_out_valid || i_ready;
    assign out_load = (r_state == ST_FIN) && out_free;
    assign o_pop    = (r_state == ST_IDLE) && i_head_valid;

    assign o_div_req.start = (r_state == ST_END) && (i_window != '0) &&
                             (r_item.frame_time != '0) && (r_item.frame_time < i_window);
    assign o_div_req.num   = r_item.frame_time;
    assign o_div_req.den   = i_window;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
            r_prod <= i_head.axis_sample * i_head.scale;
        end
        if (r_state == ST_END) begin
            r_v      <= v_tmp[VAL_W-1:0];
            r_smooth <= o_div_req.start;
        end
        if (i_div_rsp.done) begin
            r_t <= i_div_rsp.quo;
        end
        if (r_state == ST_MUL) begin
            r_sprod <= diff * $signed({1'b0, r_t});
        end
        if (out_load) begin
            r_out_value <= s_val;
            r_out_act   <= f_act;
            r_out_trig  <= f_trig;
            r_out_rel   <= f_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_flags     <= '0;
            r_latch     <= 1'b0;
            r_gain      <= SCALE_W'(ONE);
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_head_valid) r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_sum   <= n_sum;
                    r_flags <= n_flags;
                    r_latch <= n_latch;
                    r_gain  <= n_gain;
                    r_state <= r_item.last ? ST_END : ST_IDLE;
                end
                ST_END: begin
                    r_flags <= end_flags;
                    if (!r_flags[FL_HASTOG]) begin
                        r_latch <= 1'b0;
                        r_gain  <= SCALE_W'(ONE);
                    end
                    r_state <= o_div_req.start ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    if (i_div_rsp.done) r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_last      <= s_val;
                        r_sum       <= '0;
                        r_flags     <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_action_value     = r_out_value;
    assign o_action_active    = r_out_act;
    assign o_action_triggered = r_out_trig;
    assign o_action_released  = r_out_rel;
endmodule
`default_nettype wire

/* rtl/input_action_conditioner.sv */
// input_action_conditioner: conditions one game action from its bindings.
// input channel (i_valid/o_ready): one word per binding, i_last closes a frame.
// output channel (o_valid/i_ready): one word per frame with the smoothed value
// and the active, triggered and released flags.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 smoothing window, 1 analog threshold); the user writes only while the
// block is idle, which the block does not enforce. a two-entry queue takes
// input words while the back end works, which reads each binding with its
// product, then updates; a closing word then passes the end and result
// states, with smoothing also the 16-step divider for frame_time / window.
// reset clears the frame, the toggle latch, the kept value and the queue;
// window resets to zero, threshold to 0.2.
// while the receiver stalls the result is held in the output register; the
// next frame is accumulated and then waits for that register to empty.
`default_nettype none
module input_action_conditioner (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_is_axis,
    input  wire logic               i_digital_mode,
    input  wire logic               i_toggle_mode,
    input  wire logic signed [23:0] i_scale,
    input  wire logic [22:0]        i_deadzone,
    input  wire logic               i_pressed,
    input  wire logic               i_press_edge,
    input  wire logic               i_release_edge,
    input  wire logic signed [23:0] i_axis_sample,
    input  wire logic [22:0]        i_frame_time,
    input  wire logic               i_binding_valid,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [17:0]      o_action_value,
    output logic                    o_action_active,
    output logic                    o_action_triggered,
    output logic                    o_action_released,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_idx,
    input  wire logic [22:0]        i_cfg_data
);
    import iac_pkg::*;

    logic [CFG_W-1:0] r_window;
    logic [CFG_W-1:0] r_thresh;
    t_item            head;
    logic             head_valid;
    logic             pop;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_thresh <= CFG_W'(THRESH_RESET);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WINDOW: r_window <= i_cfg_data;
                REG_THRESH: r_thresh <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    iac_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_is_axis       (i_is_axis),
        .i_digital_mode  (i_digital_mode),
        .i_toggle_mode   (i_toggle_mode),
        .i_scale         (i_scale),
        .i_deadzone      (i_deadzone),
        .i_pressed       (i_pressed),
        .i_press_edge    (i_press_edge),
        .i_release_edge  (i_release_edge),
        .i_axis_sample   (i_axis_sample),
        .i_frame_time    (i_frame_time),
        .i_binding_valid (i_binding_valid),
        .i_last          (i_last),
        .o_head          (head),
        .o_head_valid    (head_valid),
        .i_pop           (pop)
    );

    iac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    iac_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (head),
        .i_head_valid       (head_valid),
        .o_pop              (pop),
        .i_window           (r_window),
        .i_thresh           (r_thresh),
        .o_div_req          (div_req),
        .i_div_rsp          (div_rsp),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_action_value     (o_action_value),
        .o_action_active    (o_action_active),
        .o_action_triggered (o_action_triggered),
        .o_action_released  (o_action_released)
    );

    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_action_value <= VAL_W'(ONE)) && (o_action_value >= -VAL_W'(ONE)))
        else $error("action value out of range");

    a_div_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider finished too early");

    a_div_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |=> !div_rsp.done)
        else $error("divider done held");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");
endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import iac_pkg::*;

    typedef struct {
        logic                      is_axis;
        logic                      digital;
        logic                      toggle;
        logic signed [SCALE_W-1:0] scale;
        logic [CFG_W-1:0]          deadzone;
        logic                      pressed;
        logic                      jp;
        logic                      jr;
        logic signed [SCALE_W-1:0] sample;
        logic [CFG_W-1:0]          ftime;
        logic                      bvalid;
        logic                      last;
    } t_word;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             active;
        logic             trig;
        logic             rel;
    } t_result;

    localparam longint LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_is_axis = 1'b0, i_digital_mode = 1'b0, i_toggle_mode = 1'b0;
    logic signed [23:0] i_scale = '0;
    logic [22:0] i_deadzone = '0;
    logic i_pressed = 1'b0, i_press_edge = 1'b0, i_release_edge = 1'b0;
    logic signed [23:0] i_axis_sample = '0;
    logic [22:0] i_frame_time = '0;
    logic i_binding_valid = 1'b0, i_last = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [17:0] o_action_value;
    logic o_action_active, o_action_triggered, o_action_released;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = '0;
    logic [22:0] i_cfg_data = '0;

    input_action_conditioner u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_word   word_q[$];
    t_result frame_q[$];
    int      errors = 0;
    int      tx_idle = 0;
    int      rx_idle = 0;
    int      hold_req = 0;
    int      hold_cnt = 0;
    longint  cycles = 0;

    // shadow of the block state
    longint     win = 0;
    longint     thr = THRESH_RESET;
    longint     acc = 0;
    logic [5:0] flags = '0;
    bit         latch_run = 0;
    bit         latch_kept = 0;
    longint     latch_gain = ONE;
    longint     prev_value = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void queue_word(t_word w);
        word_q.insert(word_q.size(), w);
    endfunction

    function automatic bit condition_word(t_word w, output t_result r);
        longint a, v, s, t, dz, sc;
        bit act, trig, rel;
        dz = longint'(w.deadzone);
        sc = longint'(w.scale);
        if (w.bvalid) begin
            if (!w.is_axis) begin
                if (w.pressed) flags[FL_PRESS] = 1'b1;
                if (w.jp) flags[FL_TRIG] = 1'b1;
                if (w.jr) flags[FL_REL] = 1'b1;
                if (w.toggle) begin
                    flags[FL_HASTOG] = 1'b1;
                    latch_gain = sc;
                    if (w.jp) begin
                        latch_run = !latch_run;
                        if (latch_run) flags[FL_ON] = 1'b1;
                        else flags[FL_OFF] = 1'b1;
                    end
                end else if (w.pressed) begin
                    acc = sat32(acc + sc);
                end
            end else begin
                a = sat32((longint'(w.sample) * sc) >>> FRAC_BITS);
                if (mag(a) <= dz) a = 0;
                if (w.digital) begin
                    act = mag(a) > dz;
                    if (act) flags[FL_PRESS] = 1'b1;
                    if (act && mag(prev_value) <= dz) flags[FL_TRIG] = 1'b1;
                    if (!act && mag(prev_value) > dz) flags[FL_REL] = 1'b1;
                    if (act) acc = sat32(acc + (a >= 0 ? sc : -sc));
                end else begin
                    acc = sat32(acc + a);
                    if (mag(a) > dz) flags[FL_PRESS] = 1'b1;
                end
            end
        end
        if (!w.last) return 0;
        v = acc;
        if (flags[FL_HASTOG]) begin
            latch_kept = latch_run;
            if (latch_run) begin
                v = sat32(v + latch_gain);
                flags[FL_PRESS] = 1'b1;
            end
            if (flags[FL_ON]) flags[FL_TRIG] = 1'b1;
            if (flags[FL_OFF]) flags[FL_REL] = 1'b1;
        end else begin
            latch_kept = 0;
            latch_run = 0;
            latch_gain = ONE;
        end
        if (v > ONE) v = ONE;
        if (v < -ONE) v = -ONE;
        s = v;
        if (win > 0 && w.ftime > 0) begin
            t = (longint'(w.ftime) << FRAC_BITS) / win;
            if (t > ONE) t = ONE;
            s = prev_value + (((v - prev_value) * t) >>> FRAC_BITS);
        end
        act = flags[FL_PRESS] || mag(s) > EPS;
        trig = flags[FL_TRIG];
        rel = flags[FL_REL];
        if (!trig && thr > 0) trig = mag(s) >= thr && mag(prev_value) < thr;
        if (!rel && thr > 0) rel = 2 * mag(s) <= thr && 2 * mag(prev_value) > thr;
        prev_value = s;
        r.value = s[VAL_W-1:0];
        r.active = act;
        r.trig = trig;
        r.rel = rel;
        acc = 0;
        flags = '0;
        latch_run = latch_kept;
        return 1;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_word   w;
        t_result r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                w = '{i_is_axis, i_digital_mode, i_toggle_mode, i_scale, i_deadzone,
                      i_pressed, i_press_edge, i_release_edge, i_axis_sample,
                      i_frame_time, i_binding_valid, i_last};
                if (condition_word(w, r)) frame_q.insert(frame_q.size(), r);
            end
            if (!i_valid || o_ready) begin
                if (word_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                    w = word_q.pop_front();
                    i_valid <= 1'b1;
                    i_is_axis <= w.is_axis;
                    i_digital_mode <= w.digital;
                    i_toggle_mode <= w.toggle;
                    i_scale <= w.scale;
                    i_deadzone <= w.deadzone;
                    i_pressed <= w.pressed;
                    i_press_edge <= w.jp;
                    i_release_edge <= w.jr;
                    i_axis_sample <= w.sample;
                    i_frame_time <= w.ftime;
                    i_binding_valid <= w.bvalid;
                    i_last <= w.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver with long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0 && hold_cnt == 0) begin
            hold_cnt <= hold_req;
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= $urandom_range(99) >= rx_idle;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result e;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_q.size() == 0) begin
                report("unexpected word", o_action_value, 0);
            end else begin
                e = frame_q.pop_front();
                if (o_action_value !== e.value)
                    report("value", o_action_value, $signed(e.value));
                if (o_action_active !== e.active) report("active", o_action_active, e.active);
                if (o_action_triggered !== e.trig)
                    report("triggered", o_action_triggered, e.trig);
                if (o_action_released !== e.rel)
                    report("released", o_action_released, e.rel);
            end
        end
    end

    function automatic logic signed [23:0] rnd_fix(bit wild);
        if (wild) return SCALE_W'($urandom);
        return SCALE_W'($signed($urandom_range(0, 4 * ONE)) - 2 * ONE);
    endfunction

    function automatic t_word rnd_word(bit wild, bit last);
        t_word w;
        w.is_axis = 1'($urandom_range(1));
        w.digital = 1'($urandom_range(1));
        w.toggle = $urandom_range(3) == 0;
        w.scale = rnd_fix(wild);
        w.deadzone = wild ? CFG_W'($urandom) : CFG_W'($urandom_range(0, ONE / 4));
        w.pressed = 1'($urandom_range(1));
        w.jp = $urandom_range(2) == 0;
        w.jr = $urandom_range(3) == 0;
        w.sample = rnd_fix(wild);
        w.ftime = wild ? CFG_W'($urandom) : CFG_W'($urandom_range(0, ONE / 8));
        w.bvalid = wild ? 1'($urandom_range(1)) : ($urandom_range(15) != 0);
        w.last = last;
        return w;
    endfunction

    function automatic t_word mk(bit axis, bit dig, bit tog, int sc, int dz, bit p, bit jp,
                                 bit jr, int smp, int ft, bit bv, bit last);
        t_word w;
        w = '{axis, dig, tog, SCALE_W'(sc), CFG_W'(dz), p, jp, jr, SCALE_W'(smp),
              CFG_W'(ft), bv, last};
        return w;
    endfunction

    task automatic wait_idle();
        while (word_q.size() > 0 || i_valid || frame_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [22:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WINDOW) win = d;
        else thr = d;
    endtask

    initial begin
        int n, k, ph;
        bit wild, noise;
        logic [22:0] wins[6];
        logic [22:0] thrs[6];
        wins = '{23'd0, 23'h7FFFFF, 23'd1, 23'd65536, 23'd262144, 23'd13107};
        thrs = '{23'd13107, 23'd0, 23'h7FFFFF, 23'd32768, 23'd1, 23'd6553};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, toggle latch, saturation, empty words
        queue_word(mk(0, 0, 0, 24'sh7FFFFF, 0, 1, 1, 0, 0, 0, 1, 1));
        queue_word(mk(0, 0, 0, -24'sh800000, 0, 1, 0, 1, 0, 23'h7FFFFF, 1, 1));
        queue_word(mk(0, 0, 1, ONE / 2, 0, 1, 1, 0, 0, 100, 1, 1));
        queue_word(mk(0, 0, 1, ONE / 2, 0, 1, 0, 0, 0, 100, 1, 1));
        queue_word(mk(0, 0, 1, -ONE, 0, 1, 1, 0, 0, 100, 1, 1));
        queue_word(mk(0, 0, 0, ONE, 0, 0, 0, 1, 0, 100, 1, 1));
        for (k = 0; k < 3; k++)
            queue_word(mk(1, 0, 0, -24'sh800000, 0, 0, 0, 0, -24'sh800000, 0, 1, k == 2));
        queue_word(mk(1, 0, 1, 24'sh7FFFFF, 23'h7FFFFF, 0, 0, 0, 24'sh7FFFFF, 0, 1, 1));
        queue_word(mk(1, 1, 0, ONE, 100, 0, 0, 0, ONE / 2, 0, 1, 1));
        queue_word(mk(1, 1, 0, -ONE, 100, 0, 0, 0, ONE / 2, 0, 1, 1));
        queue_word(mk(1, 1, 0, ONE, ONE, 0, 0, 0, 50, 0, 1, 1));
        queue_word(mk(1, 0, 0, ONE, 1000, 0, 0, 0, 500, 0, 1, 1));
        queue_word(mk(0, 0, 0, ONE, 0, 1, 1, 1, 0, 0, 0, 0));
        queue_word(mk(1, 1, 1, -1, 23'h7FFFFF, 1, 1, 1, -1, 23'h7FFFFF, 0, 1));
        queue_word(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));

        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            cfg_write(REG_WINDOW, wins[ph]);
            cfg_write(REG_THRESH, thrs[ph]);
            tx_idle = ph < 2 ? 6 : (ph < 4 ? 78 : 0);
            rx_idle = ph < 2 ? 78 : (ph < 4 ? 6 : 0);
            if (ph == 5) hold_req <= 400;
            n = 0;
            while (n < 258) begin
                wild = $urandom_range(9) == 0;
                noise = $urandom_range(19) == 0;
                k = $urandom_range(1, 5);
                repeat (k) begin
                    queue_word(rnd_word(wild, noise ? 1'($urandom_range(1)) : 1'b0));
                    n++;
                end
                queue_word(rnd_word(wild, 1'b1));
                n++;
            end
            if (ph == 5) begin
                @(posedge i_clk);
                hold_req <= 0;
            end
        end
        while (word_q.size() > 0 || i_valid || frame_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/iac_pkg.sv
rtl/iac_front.sv
rtl/iac_div.sv
rtl/iac_back.sv
rtl/input_action_conditioner.sv
test/testbench.sv
